// ===== hdl/mtag_pkg.sv =====
// mtag_pkg: shared types and constants for the Morton tile address generator.
// Holds the request/result structs, configuration layout and status codes.
// No dependencies.
package mtag_pkg;

  // Tile geometry (8x8 Z-order tiles).
  localparam int TILE_SIDE        = 8;
  localparam int TILE_SHIFT       = 3;
  localparam int MAX_SIDE_PIXELS  = 1024;
  localparam int MAX_TILES        = MAX_SIDE_PIXELS / TILE_SIDE;

  // Field widths.
  localparam int COORD_W  = 10;
  localparam int TILES_W  = 8;
  localparam int PBITS_W  = 6;
  localparam int OFFS_W   = 23;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_TILES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_TILES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_BITS   = 2'd2;

  // Supported pixel formats, in bits per pixel.
  localparam logic [PBITS_W-1:0] PIX_4  = 6'd4;
  localparam logic [PBITS_W-1:0] PIX_8  = 6'd8;
  localparam logic [PBITS_W-1:0] PIX_16 = 6'd16;
  localparam logic [PBITS_W-1:0] PIX_24 = 6'd24;
  localparam logic [PBITS_W-1:0] PIX_32 = 6'd32;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_OUT_OF_GRID = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_FORMAT  = 2'd2;

  // Configuration reset values.
  localparam logic [TILES_W-1:0] RST_WIDTH_TILES  = 8'd1;
  localparam logic [TILES_W-1:0] RST_HEIGHT_TILES = 8'd1;
  localparam logic [PBITS_W-1:0] RST_PIXEL_BITS   = 6'd32;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
  } req_t;

  typedef struct packed {
    logic [OFFS_W-1:0]   tiled_offset;
    logic [OFFS_W-1:0]   linear_offset;
    logic [STATUS_W-1:0] status;
  } res_t;

  typedef struct packed {
    logic [TILES_W-1:0] width_tiles;
    logic [TILES_W-1:0] height_tiles;
    logic [PBITS_W-1:0] pixel_bits;
  } cfg_t;

endpackage

// ===== hdl/mtag_cfg_regs.sv =====
// mtag_cfg_regs: configuration register file (tile grid size, pixel format).
// Plain write port, no read-back. Depends on mtag_pkg.
module mtag_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [mtag_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [mtag_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output mtag_pkg::cfg_t                   cfg_o
);
  import mtag_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_WIDTH_TILES:  cfg_nxt.width_tiles  = cfg_wdata[TILES_W-1:0];
        CFG_HEIGHT_TILES: cfg_nxt.height_tiles = cfg_wdata[TILES_W-1:0];
        CFG_PIXEL_BITS:   cfg_nxt.pixel_bits   = cfg_wdata[PBITS_W-1:0];
        default:          cfg_nxt = cfg_r; // unused index: drop the write
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width_tiles  <= RST_WIDTH_TILES;
      cfg_r.height_tiles <= RST_HEIGHT_TILES;
      cfg_r.pixel_bits   <= RST_PIXEL_BITS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

// ===== hdl/mtag_addr_calc.sv =====
// mtag_addr_calc: combinational address pair for one pixel (tiled and linear).
// Format/grid checks, tile index, Z-order interleave, nibble scaling. Depends on mtag_pkg.
module mtag_addr_calc (
  input  mtag_pkg::cfg_t cfg_i,
  input  mtag_pkg::req_t req_i,
  output mtag_pkg::res_t res_o
);
  import mtag_pkg::*;

  localparam int TIDX_W = 2 * TILES_W + 1;          // tile_row*wt + tx
  localparam int PROW_W = COORD_W + TILES_W;        // y*wt
  localparam int LIN_W  = PROW_W + TILE_SHIFT + 1;  // y*wt*8 + x

  // Scale a pixel index to nibbles: 1, 2, 4, 6 or 8 nibbles per pixel.
  function automatic logic [OFFS_W-1:0] scale_nib(input logic [OFFS_W-1:0] p,
                                                  input logic [PBITS_W-1:0] bits);
    logic [OFFS_W-1:0] s;
    s = '0;
    case (bits)
      PIX_4:   s = p;
      PIX_8:   s = p << 1;
      PIX_16:  s = p << 2;
      PIX_24:  s = (p << 2) + (p << 1);
      PIX_32:  s = p << 3;
      default: s = '0;
    endcase
    return s;
  endfunction

  logic [TILES_W-1:0]            wt, ht;
  logic [TILES_W+TILE_SHIFT-1:0] x_lim, y_lim;
  logic                          fmt_ok, in_grid;
  logic [COORD_W-TILE_SHIFT-1:0] tx, ty;
  logic [TILES_W-1:0]            tile_row;
  logic [TIDX_W-1:0]             tile_idx;
  logic [2*TILE_SHIFT-1:0]       zorder;
  logic [TILE_SHIFT-1:0]         in_x, in_y;
  logic [PROW_W-1:0]             row_base;
  logic [LIN_W-1:0]              lin_px;
  logic [OFFS_W-1:0]             tiled_px, linear_px;

  always_comb begin
    // Clamp oversized grid dimensions.
    wt = (int'(cfg_i.width_tiles) > MAX_TILES) ? TILES_W'(MAX_TILES) : cfg_i.width_tiles;
    ht = (int'(cfg_i.height_tiles) > MAX_TILES) ? TILES_W'(MAX_TILES) : cfg_i.height_tiles;

    case (cfg_i.pixel_bits) inside
      PIX_4, PIX_8, PIX_16, PIX_24, PIX_32: fmt_ok = 1'b1;
      default:                              fmt_ok = 1'b0;
    endcase

    x_lim   = {wt, TILE_SHIFT'(0)};
    y_lim   = {ht, TILE_SHIFT'(0)};
    in_grid = ({1'b0, req_i.pixel_x} < x_lim) && ({1'b0, req_i.pixel_y} < y_lim);

    tx   = req_i.pixel_x[COORD_W-1:TILE_SHIFT];
    ty   = req_i.pixel_y[COORD_W-1:TILE_SHIFT];
    in_x = req_i.pixel_x[TILE_SHIFT-1:0];
    in_y = ~req_i.pixel_y[TILE_SHIFT-1:0];           // rows count from the tile bottom

    // Tile rows count from the image bottom.
    tile_row = ht - TILES_W'(1) - TILES_W'(ty);
    tile_idx = TIDX_W'(tile_row) * TIDX_W'(wt) + TIDX_W'(tx);

    for (int b = 0; b < TILE_SHIFT; b++) begin
      zorder[2*b]   = in_x[b];
      zorder[2*b+1] = in_y[b];
    end

    tiled_px  = {tile_idx, zorder};
    row_base  = PROW_W'(req_i.pixel_y) * PROW_W'(wt);
    lin_px    = {1'b0, row_base, TILE_SHIFT'(0)} + LIN_W'(req_i.pixel_x);
    linear_px = OFFS_W'(lin_px);

    res_o.tiled_offset  = '0;
    res_o.linear_offset = '0;
    if (!fmt_ok) begin
      res_o.status = STATUS_BAD_FORMAT;
    end else if (!in_grid) begin
      res_o.status = STATUS_OUT_OF_GRID;
    end else begin
      res_o.status        = STATUS_OK;
      res_o.tiled_offset  = scale_nib(tiled_px, cfg_i.pixel_bits);
      res_o.linear_offset = scale_nib(linear_px, cfg_i.pixel_bits);
    end
  end

endmodule

// ===== hdl/morton_tile_address_gen.sv =====
// morton_tile_address_gen: top level of the Morton (8x8 Z-order) tile address generator.
// Instantiates mtag_cfg_regs and mtag_addr_calc; depends on mtag_pkg.
//
// Usage:
//   - Request channel: drive in_req (pixel_x, pixel_y) and pulse start. A request
//     is taken at every rising edge with start high and busy low. busy stays low,
//     so a new request may be issued in every cycle.
//   - Result channel: out_valid is high for exactly one cycle per request, with
//     out_res (tiled_offset, linear_offset, status) valid in that cycle. The
//     receiver cannot stall; results come out in request order.
//   - Pipeline: an accepted request is held in the input register, then the address
//     logic feeds the result register.
//   - Throughput: 1 request per cycle, set by the single-pass address logic
//     (one tile-row multiply and one row-base multiply in parallel, then shifts/adds).
//   - Configuration: cfg_we / cfg_idx / cfg_wdata write width_tiles (0),
//     height_tiles (1) and pixel_bits (2). Write only while no request is in flight.
//   - Reset (rst_n low, synchronous): clears the pipeline valids, loads a 1x1 tile
//     grid and 32 bits per pixel. No clearing pass is needed.
//   - status: 0 ok, 1 coordinate outside grid, 2 unsupported pixel format; on any
//     error both offsets are zero.
module morton_tile_address_gen (
  input  logic                             clk,
  input  logic                             rst_n,
  // request channel
  input  logic                             start,
  output logic                             busy,
  input  mtag_pkg::req_t                   in_req,
  // result channel
  output logic                             out_valid,
  output mtag_pkg::res_t                   out_res,
  // configuration port
  input  logic                             cfg_we,
  input  logic [mtag_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [mtag_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import mtag_pkg::*;

  cfg_t cfg;
  req_t req_r;
  logic in_vld_r;
  res_t res_nxt;
  res_t res_r;
  logic out_vld_r;
  logic accept;

  // Never hold requests off: the datapath takes one every cycle.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  mtag_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  // Input register: capture the request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_req;
    end
  end

  mtag_addr_calc u_calc (
    .cfg_i (cfg),
    .req_i (req_r),
    .res_o (res_nxt)
  );

  // Result register: present each result for one cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_res   = res_r;

  // Every accepted request reaches the input stage on the next edge.
  a_accept_to_stage: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_vld_r)
    else $error("accepted request did not reach the input stage");

  // Each accepted request yields a result once it has passed the input and result registers.
  a_accept_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> ##1 out_valid)
    else $error("result missing two cycles after request");

  // No result without a request in the input stage before it.
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_vld_r))
    else $error("result strobe without a request");

  // Error results carry zero offsets.
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_res.status != STATUS_OK)) |->
      ((out_res.tiled_offset == '0) && (out_res.linear_offset == '0)))
    else $error("error result with nonzero offset");

endmodule
